[hw/rtl/odsct_pkg.sv]
package odsct_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC        = SAMPLE_BITS - 1;
    localparam int XW          = SAMPLE_BITS + 4;   // Q5.23 internal width
    localparam int SET_W       = 17;                // Q1.16 settings
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          channel;
        logic                          block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          channel_out;
        logic                          block_end_out;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MX,  ST_X,
        ST_MX2, ST_X2, ST_MX3, ST_X3, ST_MDIV, ST_YC,
        ST_MP,  ST_IDX, ST_ME, ST_YE,
        ST_MC,  ST_C,  ST_MLP, ST_LP,
        ST_MW1, ST_W1, ST_MW2, ST_W2,
        ST_ML,  ST_WL, ST_MD,  ST_MM,
        ST_OUT, ST_FIN
    } t_state;

endpackage

[hw/rtl/odsct_mul.sv]
module odsct_mul #(
    parameter int AW = 30,
    parameter int BW = 26
) (
    input  logic                    i_clk,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_prod
);

    logic signed [AW+BW-1:0] r_prod;

    // registered product, consumed in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/overdrive_soft_clip_tone_unit.sv]
// Overdrive with soft clipping and a per-channel one-pole tone filter for
// Q1.23 stereo samples. Settings (drive, tone, level, wet mix) are Q1.16; the
// user is to write them through the config port only while the unit is idle,
// which the block itself does not enforce; values above 1.0 act as 1.0. Each
// processed item goes through one shared signed multiplier under a small
// sequencer, so the unit takes one item at a time. A bypassed item goes from
// idle straight to the step that loads the output register; a processed item
// runs the cubic or the exp-table path first. The sequencer then returns to
// idle, where the next item is accepted, even while the last result still
// waits on a stalled output. A finished item whose output slot is still full
// and stalled holds the sequencer until the slot frees. The exp table is
// built at elaboration from EXP_TABLE_DEPTH and read as constant logic.
module overdrive_soft_clip_tone_unit
    import odsct_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int CHANNELS        = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SET_W-1:0]     i_cfg_data
);

    localparam int AW  = SAMPLE_BITS + 6;
    localparam int BW  = 26;
    localparam int PW  = AW + BW;
    localparam int IW  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // floor(n/3) = (n*DIV3_M) >> DIV3_K, exact for n below 2^(FRAC+1)
    localparam int DIV3_K = FRAC + 2;
    localparam longint DIV3_M = ((64'sd1 <<< DIV3_K) + 2) / 3;
    localparam logic signed [XW-1:0] ONE_X = XW'(64'sd1 <<< FRAC);
    localparam logic signed [PW-1:0] H16   = PW'(64'sd1 <<< 15);
    localparam logic signed [PW-1:0] H17   = PW'(64'sd1 <<< 16);
    localparam logic signed [PW-1:0] HF    = PW'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< FRAC) - 1);
    localparam logic signed [PW-1:0] SAT_LO = -PW'(64'sd1 <<< FRAC);

    // ---------------- exp table, built at elaboration ----------------
    // restoring division for non-negative operands, table build only
    function automatic longint udiv(longint num, longint den);
        longint q;
        longint rem;
        int     b;
        q   = 0;
        rem = 0;
        for (b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // exp(-r/D) in Q.32 by a truncated Taylor sum
    function automatic longint exp_frac(longint r);
        longint term;
        longint sum;
        int     k;
        term = 64'sd1 <<< 32;
        sum  = term;
        for (k = 1; k <= 24; k++) begin
            term = udiv(term * r, longint'(EXP_TABLE_DEPTH) * k);
            sum  = ((k & 1) == 1) ? sum - term : sum + term;
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 32)) sum = 64'sd1 <<< 32;
        return sum;
    endfunction

    // exp(-16*i/D) in Q.FRAC
    function automatic longint unsigned exp_entry(int i);
        longint unsigned e1;
        longint unsigned v;
        longint          t;
        longint          q;
        int              n;
        int              j;
        e1 = longint'(exp_frac(longint'(EXP_TABLE_DEPTH)));
        t  = 16 * longint'(i);
        q  = udiv(t, longint'(EXP_TABLE_DEPTH));
        n  = int'(q);
        v  = longint'(exp_frac(t - q * longint'(EXP_TABLE_DEPTH)));
        for (j = 0; j < n; j++) begin
            v = (v * e1 + (64'd1 << 31)) >> 32;
        end
        return (v + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
    endfunction

    logic [SAMPLE_BITS-1:0] w_exp_tab [0:EXP_TABLE_DEPTH];

    for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_exp
        assign w_exp_tab[gi] = SAMPLE_BITS'(exp_entry(gi));
    end

    function automatic logic [SET_W-1:0] clamp_set(logic [SET_W-1:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    // ---------------- registers ----------------
    t_state                  r_state, n_state;
    logic                    r_bypass;
    logic [SET_W-1:0]        r_drive, r_tone, r_level, r_mix;
    logic signed [XW-1:0]    r_lp [0:CHANNELS-1];

    logic signed [SAMPLE_BITS-1:0] r_s;
    logic                    r_ch, r_be;
    logic [CW-1:0]           r_sel;
    logic signed [XW-1:0]    r_x, r_t, r_y;
    logic [SET_W-1:0]        r_c;
    logic [15:0]             r_frac;
    logic signed [SAMPLE_BITS:0] r_diff;
    logic signed [PW-1:0]    r_acc;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                    r_out_valid;
    t_out_item               r_out;

    // ---------------- shared multiplier ----------------
    logic signed [AW-1:0]    w_ma;
    logic signed [BW-1:0]    w_mb;
    logic signed [PW-1:0]    w_prod;

    odsct_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // ---------------- derived values ----------------
    logic [SET_W-1:0]        w_drive, w_tone, w_level, w_mix;
    logic [19:0]             w_gain;
    logic signed [XW-1:0]    w_lp_sel;
    logic signed [PW-1:0]    w_r16, w_r17, w_rf, w_fin;
    logic signed [PW:0]      w_sum;
    logic [XW-1:0]           w_abs_x, w_a_cl;
    logic [SAMPLE_BITS-1:0]  w_abs_x3;
    logic signed [XW-1:0]    w_third, w_e;
    logic signed [XW:0]      w_ydiff;
    logic [IW-1:0]           w_idx, w_idx1;
    logic                    w_accept, w_out_take;

    assign w_drive  = clamp_set(r_drive);
    assign w_tone   = clamp_set(r_tone);
    assign w_level  = clamp_set(r_level);
    assign w_mix    = clamp_set(r_mix);
    // 1 + 10*drive in Q.16
    assign w_gain   = 20'd65536 + (20'(w_drive) << 3) + (20'(w_drive) << 1);
    assign w_lp_sel = r_lp[r_sel];

    // round-to-nearest shifts of the last product
    assign w_r16 = (w_prod + H16) >>> 16;
    assign w_r17 = (w_prod + H17) >>> 17;
    assign w_rf  = (w_prod + HF) >>> FRAC;
    assign w_sum = (PW+1)'(r_acc) + (PW+1)'(w_prod) + (PW+1)'(H16);
    assign w_fin = PW'(w_sum >>> 16);

    assign w_abs_x  = r_x[XW-1] ? XW'(-r_x) : XW'(r_x);
    // exp argument saturates just below sixteen
    assign w_a_cl   = w_abs_x[XW-1] ? {1'b0, {(XW-1){1'b1}}} : w_abs_x;
    assign w_abs_x3 = r_t[XW-1] ? SAMPLE_BITS'(-r_t) : SAMPLE_BITS'(r_t);
    assign w_third  = XW'(w_prod >>> DIV3_K);
    assign w_e      = r_t + XW'(w_r16);
    assign w_ydiff  = {r_y[XW-1], r_y} - {w_lp_sel[XW-1], w_lp_sel};

    // table index and 16-bit interpolation fraction from p = a*D
    assign w_idx  = w_prod[FRAC+4 +: IW];
    assign w_idx1 = w_idx + IW'(1);

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- operand select ----------------
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_MX: begin
                w_ma = AW'(r_s);
                w_mb = signed'(BW'(w_gain));
            end
            ST_MX2: begin
                w_ma = AW'(r_x);
                w_mb = BW'(r_x);
            end
            ST_MX3: begin
                w_ma = AW'(r_t);
                w_mb = BW'(r_x);
            end
            ST_MDIV: begin
                w_ma = signed'(AW'(w_abs_x3) + AW'(1));
                w_mb = BW'(DIV3_M);
            end
            ST_MP: begin
                w_ma = signed'(AW'(w_a_cl));
                w_mb = BW'(EXP_TABLE_DEPTH);
            end
            ST_ME: begin
                w_ma = AW'(r_diff);
                w_mb = signed'(BW'(r_frac));
            end
            ST_MC: begin
                w_ma = signed'(AW'(w_tone));
                w_mb = BW'(52429);
            end
            ST_MLP: begin
                w_ma = AW'(w_ydiff);
                w_mb = signed'(BW'(r_c));
            end
            ST_MW1: begin
                w_ma = AW'(w_lp_sel);
                w_mb = signed'(BW'(w_tone));
            end
            ST_MW2: begin
                w_ma = AW'(r_y);
                w_mb = signed'(BW'(18'd131072 - 18'(w_tone)));
            end
            ST_ML: begin
                w_ma = AW'(r_t);
                w_mb = signed'(BW'(w_level));
            end
            ST_MD: begin
                w_ma = AW'(r_s);
                w_mb = signed'(BW'(17'd65536 - w_mix));
            end
            ST_MM: begin
                w_ma = AW'(r_t);
                w_mb = signed'(BW'(w_mix));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // ---------------- sequencer next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = r_bypass ? ST_FIN : ST_MX;
            ST_MX:   n_state = ST_X;
            ST_X:    n_state = ST_MX2;  // refined below
            ST_MX2:  n_state = ST_X2;
            ST_X2:   n_state = ST_MX3;
            ST_MX3:  n_state = ST_X3;
            ST_X3:   n_state = ST_MDIV;
            ST_MDIV: n_state = ST_YC;
            ST_YC:   n_state = ST_MC;
            ST_MP:   n_state = ST_IDX;
            ST_IDX:  n_state = ST_ME;
            ST_ME:   n_state = ST_YE;
            ST_YE:   n_state = ST_MC;
            ST_MC:   n_state = ST_C;
            ST_C:    n_state = ST_MLP;
            ST_MLP:  n_state = ST_LP;
            ST_LP:   n_state = ST_MW1;
            ST_MW1:  n_state = ST_W1;
            ST_W1:   n_state = ST_MW2;
            ST_MW2:  n_state = ST_W2;
            ST_W2:   n_state = ST_ML;
            ST_ML:   n_state = ST_WL;
            ST_WL:   n_state = ST_MD;
            ST_MD:   n_state = ST_MM;
            ST_MM:   n_state = ST_OUT;
            ST_OUT:  n_state = ST_FIN;
            ST_FIN:  if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        // x from the gain product picks the cubic or the exp path
        if (r_state == ST_X) begin
            if ((XW'(w_r16) > ONE_X) || (XW'(w_r16) < -ONE_X)) n_state = ST_MP;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bypass    <= 1'b0;
            r_drive     <= 17'd32768;
            r_tone      <= 17'd32768;
            r_level     <= 17'd32768;
            r_mix       <= 17'd65536;
            for (int i = 0; i < CHANNELS; i++) begin
                r_lp[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BYPASS: r_bypass <= i_cfg_data[0];
                    CFG_DRIVE:  r_drive  <= i_cfg_data;
                    CFG_TONE:   r_tone   <= i_cfg_data;
                    CFG_LEVEL:  r_level  <= i_cfg_data;
                    CFG_MIX:    r_mix    <= i_cfg_data;
                    default: ;  // unknown index ignored
                endcase
            end
            if (r_state == ST_LP) begin
                r_lp[r_sel] <= w_lp_sel + XW'(w_r16);
            end
            if (r_state == ST_FIN && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_s   <= i_in_data.sample_in;
                r_res <= i_in_data.sample_in;   // bypass result
                r_ch  <= i_in_data.channel;
                r_be  <= i_in_data.block_end;
                // tags beyond the channel count share the last state
                r_sel <= ({31'd0, i_in_data.channel} < CHANNELS) ?
                         CW'(i_in_data.channel) : CW'(CHANNELS - 1);
            end
            ST_X:   r_x <= XW'(w_r16);
            ST_X2:  r_t <= XW'(w_rf);
            ST_X3:  r_t <= XW'(w_rf);
            ST_YC:  r_y <= r_t[XW-1] ? r_x + w_third : r_x - w_third;
            ST_IDX: begin
                r_t    <= signed'(XW'(w_exp_tab[w_idx]));
                r_diff <= signed'((SAMPLE_BITS+1)'(w_exp_tab[w_idx1]))
                        - signed'((SAMPLE_BITS+1)'(w_exp_tab[w_idx]));
                r_frac <= w_prod[FRAC-12 +: 16];
            end
            ST_YE:  r_y <= r_x[XW-1] ? w_e - ONE_X : ONE_X - w_e;
            ST_C:   r_c <= 17'd6554 + SET_W'(w_r16);
            ST_W1:  r_t <= XW'(w_r16);
            ST_W2:  r_t <= r_t + XW'(w_r17);
            ST_WL:  r_t <= XW'(w_r16);
            ST_MM:  r_acc <= w_prod;
            ST_OUT: begin
                if (w_fin > SAT_HI) begin
                    r_res <= SAMPLE_BITS'(SAT_HI);
                end else if (w_fin < SAT_LO) begin
                    r_res <= SAMPLE_BITS'(SAT_LO);
                end else begin
                    r_res <= SAMPLE_BITS'(w_fin);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out.sample_out    <= r_res;
                    r_out.channel_out   <= r_ch;
                    r_out.block_end_out <= r_be;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // an accepted item always starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    // filter state of channel 0 moves only in the update step
    a_lp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LP) |=> $stable(r_lp[0]))
        else $error("lowpass state changed outside update step");

    // finished result waits while the output slot is full and stalled
    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && i_out_stall) |=> (r_state == ST_FIN))
        else $error("result dropped on a stalled output");

    // output valid rises only from the final step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("output valid without a finished item");
`endif

endmodule
